FILE: design/assert_macros.svh
// assertion macros for the stack machine core
// used by the top level only, expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every edge, also during reset
`define SMC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// checked only out of reset
`define SMC_ASSERT_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

FILE: design/smc_pkg.sv
// shared types and constants of the stack machine core
// no dependencies
package smc_pkg;

  localparam int MEM_WORDS     = 1024;
  localparam int STACK_ENTRIES = 64;

  localparam logic [15:0] CHAR_LIMIT = 16'd65;

  typedef enum logic [15:0] {
    OP_HALT = 16'd0,
    OP_PUSH = 16'd1,
    OP_ADD  = 16'd2,
    OP_DUP  = 16'd3,
    OP_SWAP = 16'd4,
    OP_POP  = 16'd5,
    OP_PULL = 16'd6,
    OP_OUT  = 16'd7,
    OP_BRZ  = 16'd8,
    OP_RETZ = 16'd9
  } opcode_t;

  typedef enum logic [2:0] {
    FAULT_NONE   = 3'd0,
    FAULT_OPCODE = 3'd1,
    FAULT_CHAR   = 3'd2,
    FAULT_OVER   = 3'd3,
    FAULT_UNDER  = 3'd4
  } fault_t;

  typedef enum logic {
    ITEM_LOAD = 1'b0,
    ITEM_STEP = 1'b1
  } item_op_t;

  typedef struct packed {
    logic issue;
    logic fire;
    logic is_step;
  } ctrl_t;

  typedef struct packed {
    logic        out_flag;
    logic [15:0] value;
    logic        halted;
    fault_t      fault;
  } result_t;

endpackage

FILE: design/smc_fetch.sv
// program memory with a load write port and two fetch read ports
// depends on smc_pkg
module smc_fetch #(
  parameter int MEM_WORDS = smc_pkg::MEM_WORDS
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(MEM_WORDS)-1:0] wr_addr,
  input  logic [15:0]                  wr_data,
  input  logic                         rd_en,
  input  logic [$clog2(MEM_WORDS)-1:0] rd_addr,
  output logic [15:0]                  instr,
  output logic [15:0]                  lit
);

  localparam int AW = $clog2(MEM_WORDS);

  logic [15:0] prog_mem [MEM_WORDS];
  logic [AW-1:0] lit_addr;

  assign lit_addr = rd_addr + AW'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prog_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      instr <= prog_mem[rd_addr];
      lit   <= prog_mem[lit_addr];
    end
  end

endmodule

FILE: design/smc_exec.sv
// execute stage: data stack and frame stack memories, machine registers
// depends on smc_pkg
module smc_exec #(
  parameter int MEM_WORDS     = smc_pkg::MEM_WORDS,
  parameter int STACK_ENTRIES = smc_pkg::STACK_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  smc_pkg::ctrl_t               ctrl,
  input  logic                         char_mode,
  input  logic [15:0]                  instr,
  input  logic [15:0]                  lit,
  output logic [$clog2(MEM_WORDS)-1:0] pc,
  output smc_pkg::result_t             res
);

  localparam int AW  = $clog2(MEM_WORDS);
  localparam int SIW = $clog2(STACK_ENTRIES);
  localparam int DW  = $clog2(STACK_ENTRIES + 1);
  localparam logic [SIW-1:0] FI_LAST = SIW'(STACK_ENTRIES - 1);
  localparam logic [DW-1:0]  D_FULL  = DW'(STACK_ENTRIES);

  logic [15:0]   data_mem  [STACK_ENTRIES];
  logic [AW-1:0] frame_mem [STACK_ENTRIES];

  logic [AW-1:0]  pc_r, pc_nxt;
  logic [DW-1:0]  depth_r, depth_nxt;
  logic [SIW-1:0] fi_r, fi_nxt;
  logic [15:0]    tos_r, tos_nxt;
  logic [15:0]    hold_r, hold_nxt;
  logic           halt_r, halt_nxt;

  logic [15:0]   second_q, third_q;
  logic [AW-1:0] ret_q;

  logic           ds_we, fs_we;
  logic [SIW-1:0] ds_waddr;
  logic [AW-1:0]  pc_seq, pc_lit;
  logic           d_ge1, d_ge2, d_full;
  smc_pkg::fault_t fault;

  assign pc     = pc_r;
  assign pc_seq = pc_r + AW'(1);
  assign pc_lit = pc_r + AW'(2);
  assign d_ge1  = depth_r != '0;
  assign d_ge2  = depth_r >= DW'(2);
  assign d_full = depth_r >= D_FULL;

  // operand reads at issue, write-back at fire
  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      second_q <= data_mem[SIW'(depth_r - DW'(2))];
      third_q  <= data_mem[SIW'(depth_r - DW'(3))];
      ret_q    <= frame_mem[fi_r - SIW'(1)];
    end
    if (ds_we) begin
      data_mem[ds_waddr] <= tos_r;
    end
    if (fs_we) begin
      frame_mem[fi_r] <= pc_seq;
    end
  end

  always_comb begin
    pc_nxt    = pc_r;
    depth_nxt = depth_r;
    fi_nxt    = fi_r;
    tos_nxt   = tos_r;
    hold_nxt  = hold_r;
    halt_nxt  = halt_r;
    ds_we     = 1'b0;
    fs_we     = 1'b0;
    ds_waddr  = SIW'(depth_r - DW'(1));
    fault     = smc_pkg::FAULT_NONE;
    res.out_flag = 1'b0;
    res.value    = '0;
    if (ctrl.fire && ctrl.is_step && !halt_r) begin
      pc_nxt = pc_seq;
      unique case (instr)
        smc_pkg::OP_HALT: begin
          halt_nxt = 1'b1;
        end
        smc_pkg::OP_PUSH: begin
          pc_nxt = pc_lit;
          if (d_full) begin
            fault = smc_pkg::FAULT_OVER;
          end else begin
            ds_we     = d_ge1;
            tos_nxt   = lit;
            depth_nxt = depth_r + DW'(1);
          end
        end
        smc_pkg::OP_ADD: begin
          if (!d_ge2) begin
            fault = smc_pkg::FAULT_UNDER;
          end else begin
            tos_nxt   = tos_r + second_q;
            depth_nxt = depth_r - DW'(1);
          end
        end
        smc_pkg::OP_DUP: begin
          if (!d_ge1) begin
            fault = smc_pkg::FAULT_UNDER;
          end else if (d_full) begin
            fault = smc_pkg::FAULT_OVER;
          end else begin
            ds_we     = 1'b1;
            depth_nxt = depth_r + DW'(1);
          end
        end
        smc_pkg::OP_SWAP: begin
          if (!d_ge2) begin
            fault = smc_pkg::FAULT_UNDER;
          end else begin
            ds_we    = 1'b1;
            ds_waddr = SIW'(depth_r - DW'(2));
            tos_nxt  = second_q;
          end
        end
        smc_pkg::OP_POP: begin
          if (!d_ge1) begin
            fault = smc_pkg::FAULT_UNDER;
          end else begin
            hold_nxt  = tos_r;
            tos_nxt   = second_q;
            depth_nxt = depth_r - DW'(1);
          end
        end
        smc_pkg::OP_PULL: begin
          if (d_full) begin
            fault = smc_pkg::FAULT_OVER;
          end else begin
            ds_we     = d_ge1;
            tos_nxt   = hold_r;
            depth_nxt = depth_r + DW'(1);
          end
        end
        smc_pkg::OP_OUT: begin
          if (!d_ge1) begin
            fault = smc_pkg::FAULT_UNDER;
          end else if (char_mode && (tos_r < 16'd1 || tos_r >= smc_pkg::CHAR_LIMIT)) begin
            fault = smc_pkg::FAULT_CHAR;
          end else begin
            res.out_flag = 1'b1;
            res.value    = tos_r;
          end
        end
        smc_pkg::OP_BRZ: begin
          if (!d_ge2) begin
            fault = smc_pkg::FAULT_UNDER;
          end else if (second_q == '0 && fi_r == FI_LAST) begin
            fault = smc_pkg::FAULT_OVER;
          end else begin
            depth_nxt = depth_r - DW'(2);
            tos_nxt   = third_q;
            if (second_q == '0) begin
              fs_we  = 1'b1;
              fi_nxt = fi_r + SIW'(1);
              pc_nxt = tos_r[AW-1:0];
            end
          end
        end
        smc_pkg::OP_RETZ: begin
          if (!d_ge1) begin
            fault = smc_pkg::FAULT_UNDER;
          end else if (tos_r == '0 && fi_r == '0) begin
            fault = smc_pkg::FAULT_UNDER;
          end else begin
            depth_nxt = depth_r - DW'(1);
            tos_nxt   = second_q;
            if (tos_r == '0) begin
              fi_nxt = fi_r - SIW'(1);
              pc_nxt = ret_q;
            end
          end
        end
        default: begin
          fault = smc_pkg::FAULT_OPCODE;
        end
      endcase
      // a fault leaves everything but the program counter alone
      if (fault != smc_pkg::FAULT_NONE) begin
        depth_nxt = depth_r;
        fi_nxt    = fi_r;
        tos_nxt   = tos_r;
        hold_nxt  = hold_r;
        ds_we     = 1'b0;
        fs_we     = 1'b0;
      end
    end
    res.halted = halt_nxt;
    res.fault  = fault;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= '0;
      depth_r <= '0;
      fi_r    <= '0;
      hold_r  <= '0;
      halt_r  <= 1'b0;
    end else if (ctrl.fire) begin
      pc_r    <= pc_nxt;
      depth_r <= depth_nxt;
      fi_r    <= fi_nxt;
      hold_r  <= hold_nxt;
      halt_r  <= halt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      tos_r <= tos_nxt;
    end
  end

endmodule

FILE: design/stack_machine_core_top.sv
// top level of the stack machine core: handshakes, result register, char mode
// depends on smc_pkg, smc_fetch, smc_exec and assert_macros.svh
//
// channel  | ports                                             | dir
// ---------+---------------------------------------------------+-----
// input    | in_valid in_stall in_op in_address in_data        | in
// result   | out_valid out_stall out_out_valid out_out_value   | out
//          | out_halted out_fault                              |
// config   | cfg_wr_en cfg_wr_data                             | in
//
// for a step item, the accept edge issues the memory reads at the current pc, stack
// depth and frame index; the item then executes and writes back once the result
// register can take its result, as the memories are read through registers.
// reset clears the machine registers but the top of stack; memories need no clearing.
// a stalled result waits in the output register; one more item may be taken
// meanwhile and holds in execute until the result register frees.
`include "assert_macros.svh"

module stack_machine_core_top #(
  parameter int MEM_WORDS     = smc_pkg::MEM_WORDS,
  parameter int STACK_ENTRIES = smc_pkg::STACK_ENTRIES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [9:0]  in_address,
  input  logic [15:0] in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_out_valid,
  output logic [15:0] out_out_value,
  output logic        out_halted,
  output logic [2:0]  out_fault,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  localparam int AW = $clog2(MEM_WORDS);

  logic ex_valid_r, ex_valid_nxt;
  logic ex_step_r;
  logic out_valid_r, out_valid_nxt;
  logic char_mode_r;
  logic in_accept, ex_fire, load_wr;

  logic [AW-1:0] pc;
  logic [15:0]   instr, lit;

  smc_pkg::ctrl_t   ctrl;
  smc_pkg::result_t res;
  smc_pkg::result_t res_r;

  assign in_stall  = ex_valid_r;
  assign in_accept = in_valid && !in_stall;
  assign ex_fire   = ex_valid_r && (!out_valid_r || !out_stall);
  assign load_wr   = in_accept && (in_op == smc_pkg::ITEM_LOAD);

  assign ctrl.issue   = in_accept && (in_op == smc_pkg::ITEM_STEP);
  assign ctrl.fire    = ex_fire;
  assign ctrl.is_step = ex_step_r;

  assign ex_valid_nxt  = in_accept ? 1'b1 : (ex_fire ? 1'b0 : ex_valid_r);
  assign out_valid_nxt = ex_fire ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  smc_fetch #(
    .MEM_WORDS (MEM_WORDS)
  ) u_fetch (
    .clk     (clk),
    .wr_en   (load_wr),
    .wr_addr (AW'(in_address)),
    .wr_data (in_data),
    .rd_en   (ctrl.issue),
    .rd_addr (pc),
    .instr   (instr),
    .lit     (lit)
  );

  smc_exec #(
    .MEM_WORDS     (MEM_WORDS),
    .STACK_ENTRIES (STACK_ENTRIES)
  ) u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .char_mode (char_mode_r),
    .instr     (instr),
    .lit       (lit),
    .pc        (pc),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      char_mode_r <= 1'b0;
    end else begin
      ex_valid_r  <= ex_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        char_mode_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      ex_step_r <= in_op;
    end
    if (ex_fire) begin
      res_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_out_valid = res_r.out_flag;
  assign out_out_value = res_r.value;
  assign out_halted    = res_r.halted;
  assign out_fault     = res_r.fault;

  `SMC_ASSERT_ALWAYS(a_accept_enters_ex, in_accept |=> ex_valid_r, "accepted transaction lost")
  `SMC_ASSERT_ON(a_halt_sticky, out_valid && out_halted |=> out_halted, "halt flag cleared")
  `SMC_ASSERT_ON(a_halted_quiet, out_valid && out_halted |-> !out_out_valid && out_fault == smc_pkg::FAULT_NONE, "halted machine produced output or fault")
  `SMC_ASSERT_ON(a_fault_no_out, out_valid && out_fault != smc_pkg::FAULT_NONE |-> !out_out_valid, "faulting step emitted a value")

endmodule
